// ----- sv/elg_pkg.sv -----
// Package for the ElGamal block: control word types, step addresses and the microcode table.
package elg_pkg;

  typedef logic [3:0] pc_t;

  // Operand sources of the modular multiplier.
  typedef enum logic [2:0] {
    X_GEN,
    X_PUB,
    X_EPH,
    X_ACC,
    X_SQ,
    X_DAT
  } x_sel_e;

  typedef enum logic [1:0] {
    A_ONE,
    A_ACC,
    A_SQ
  } a_sel_e;

  typedef enum logic [1:0] {
    D_NONE,
    D_ACC,
    D_SQ
  } dst_e;

  typedef enum logic [1:0] {
    EXP_NONE,
    EXP_SENDER,
    EXP_DEC
  } exp_ld_e;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_MOD_SMALL,
    JC_BIT_CLR,
    JC_MORE,
    JC_DECRYPT
  } jc_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_MUL,
    OUT_ZERO
  } out_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODULUS,
    REG_GENERATOR,
    REG_PUBLIC_KEY,
    REG_RECEIVER_KEY,
    REG_SENDER_KEY
  } reg_idx_e;

  // Request kinds carried in tuser.
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic    mul;
    x_sel_e  x_sel;
    a_sel_e  a_sel;
    dst_e    dst;
    exp_ld_e exp_ld;
    logic    acc_init;
    logic    exp_shift;
    logic    eph_ld;
    jc_e     jc;
    pc_t     target;
    out_e    out;
  } ctl_t;

  // Step addresses.
  localparam pc_t PC_CHK  = 4'd0;
  localparam pc_t PC_LDA  = 4'd1;
  localparam pc_t PC_LPA  = 4'd2;
  localparam pc_t PC_MLA  = 4'd3;
  localparam pc_t PC_SQA  = 4'd4;
  localparam pc_t PC_EPH  = 4'd5;
  localparam pc_t PC_LDE  = 4'd6;
  localparam pc_t PC_LDD  = 4'd7;
  localparam pc_t PC_LPB  = 4'd8;
  localparam pc_t PC_MLB  = 4'd9;
  localparam pc_t PC_SQB  = 4'd10;
  localparam pc_t PC_FIN  = 4'd11;
  localparam pc_t PC_ZERO = 4'd12;

  localparam ctl_t CTL_NOP = '{
    mul: 1'b0, x_sel: X_ACC, a_sel: A_ONE, dst: D_NONE, exp_ld: EXP_NONE,
    acc_init: 1'b0, exp_shift: 1'b0, eph_ld: 1'b0, jc: JC_NONE,
    target: PC_CHK, out: OUT_NONE
  };

  function automatic ctl_t ucode_rom(pc_t pc);
    ctl_t w;
    w = CTL_NOP;
    unique case (pc)
      // A modulus below two gives all-zero results.
      PC_CHK: begin
        w.jc = JC_MOD_SMALL;
        w.target = PC_ZERO;
      end
      // First power: generator^sender_key.
      PC_LDA: begin
        w.mul = 1'b1; w.x_sel = X_GEN; w.a_sel = A_ONE; w.dst = D_SQ;
        w.exp_ld = EXP_SENDER; w.acc_init = 1'b1;
      end
      PC_LPA: begin
        w.jc = JC_BIT_CLR; w.target = PC_SQA;
      end
      PC_MLA: begin
        w.mul = 1'b1; w.x_sel = X_ACC; w.a_sel = A_SQ; w.dst = D_ACC;
      end
      PC_SQA: begin
        w.mul = 1'b1; w.x_sel = X_SQ; w.a_sel = A_SQ; w.dst = D_SQ;
        w.exp_shift = 1'b1; w.jc = JC_MORE; w.target = PC_LPA;
      end
      PC_EPH: begin
        w.eph_ld = 1'b1; w.jc = JC_DECRYPT; w.target = PC_LDD;
      end
      // Second power: public_key^sender_key for encrypt.
      PC_LDE: begin
        w.mul = 1'b1; w.x_sel = X_PUB; w.a_sel = A_ONE; w.dst = D_SQ;
        w.exp_ld = EXP_SENDER; w.acc_init = 1'b1;
        w.jc = JC_ALWAYS; w.target = PC_LPB;
      end
      // Second power: ephemeral^(p-1-receiver_key) for decrypt.
      PC_LDD: begin
        w.mul = 1'b1; w.x_sel = X_EPH; w.a_sel = A_ONE; w.dst = D_SQ;
        w.exp_ld = EXP_DEC; w.acc_init = 1'b1;
      end
      PC_LPB: begin
        w.jc = JC_BIT_CLR; w.target = PC_SQB;
      end
      PC_MLB: begin
        w.mul = 1'b1; w.x_sel = X_ACC; w.a_sel = A_SQ; w.dst = D_ACC;
      end
      PC_SQB: begin
        w.mul = 1'b1; w.x_sel = X_SQ; w.a_sel = A_SQ; w.dst = D_SQ;
        w.exp_shift = 1'b1; w.jc = JC_MORE; w.target = PC_LPB;
      end
      PC_FIN: begin
        w.mul = 1'b1; w.x_sel = X_DAT; w.a_sel = A_ACC; w.dst = D_NONE;
        w.out = OUT_MUL;
      end
      default: begin
        w.out = OUT_ZERO;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/elgamal_char_encrypt_decrypt.sv -----
// Top level of the ElGamal encrypt/decrypt block with its microcoded sequencer and datapath.
//
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid, tready, tdata, tuser     tdata: data_value; tuser: req_type
// m_axis    out        tvalid, tready, tdata            tdata: result_value, ephemeral_key
// cfg       in         cfg_we_i, cfg_index_i, cfg_data_i  one register write per cycle
//
// One item at a time. Every modular multiplication runs through one bit-serial
// multiply-and-reduce unit (W = VALUE_WIDTH), one multiplier bit per cycle. With a
// modulus below two the item returns zeros. Reset clears the sequencer and output
// valid and loads the register defaults. A finished result waits in an output
// register while the next transaction is taken; only the final multiply or the zero
// result of the next item waits for that register to drain.
module elgamal_char_encrypt_decrypt
  import elg_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]   cfg_data_i,
  // Request stream.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [W-1:0] data_value
  input  logic                     s_axis_tuser,          // [0] req_type
  // Result stream.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata  // [W-1:0] result_value,
                                                          // [2W-1:W] ephemeral_key
);

  localparam int W     = VALUE_WIDTH;
  localparam int CW    = $clog2(W);
  localparam int OUT_W = ((2*W+7)/8)*8;

  // Configuration registers.
  logic [W-1:0] mod_q, gen_q, pub_q, rkey_q, skey_q;

  // Sequencer state.
  logic         busy_q;
  pc_t          pc_q;
  ctl_t         word;

  // Working registers.
  logic         kind_q;
  logic [W-1:0] dat_q, acc_q, sq_q, eph_q, exp_q;
  logic [CW-1:0] cnt_q;

  // Multiplier state: mr accumulates the residue, mx is scanned from its top bit.
  logic          mul_run_q;
  logic [W-1:0]  mr_q, mx_q, ma_q;
  logic [CW-1:0] mcnt_q;
  logic          mul_last;

  // Output register.
  logic         m_valid_q;
  logic [W-1:0] out_res_q, out_eph_q;

  logic         in_acc, out_free, mul_go, step_done, jump;
  logic [W-1:0] x_val, a_val, red, exp_dec;
  logic [W+1:0] sum, sum_m1, sum_m2, p1, p2;

  assign word     = ucode_rom(pc_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign mul_last = (mcnt_q == CW'(W-1));

  // The final multiply only starts once the output register can take its result.
  assign mul_go = busy_q && word.mul && !mul_run_q && (word.out == OUT_NONE || out_free);

  always_comb begin
    step_done = 1'b0;
    if (busy_q) begin
      if (word.mul) begin
        step_done = mul_run_q && mul_last;
      end else begin
        step_done = (word.out == OUT_NONE) || out_free;
      end
    end
  end

  always_comb begin
    unique case (word.x_sel)
      X_GEN:   x_val = gen_q;
      X_PUB:   x_val = pub_q;
      X_EPH:   x_val = eph_q;
      X_ACC:   x_val = acc_q;
      X_SQ:    x_val = sq_q;
      X_DAT:   x_val = dat_q;
      default: x_val = dat_q;
    endcase
  end

  always_comb begin
    unique case (word.a_sel)
      A_ONE:   a_val = W'(1);
      A_ACC:   a_val = acc_q;
      A_SQ:    a_val = sq_q;
      default: a_val = W'(1);
    endcase
  end

  // One interleaved step: r = 2r + bit*a, then bring it back below p.
  // With r and a below p the sum stays below 3p, so one of two subtractions suffices.
  always_comb begin
    p1     = {2'b00, mod_q};
    p2     = {1'b0, mod_q, 1'b0};
    sum    = {1'b0, mr_q, 1'b0} + (mx_q[W-1] ? {2'b00, ma_q} : '0);
    sum_m1 = sum - p1;
    sum_m2 = sum - p2;
    if (sum >= p2) begin
      red = sum_m2[W-1:0];
    end else if (sum >= p1) begin
      red = sum_m1[W-1:0];
    end else begin
      red = sum[W-1:0];
    end
  end

  // Decrypt exponent p-1-a, taken as zero when the receiver key is too large.
  assign exp_dec = (rkey_q < mod_q) ? (mod_q - W'(1) - rkey_q) : '0;

  always_comb begin
    unique case (word.jc)
      JC_NONE:      jump = 1'b0;
      JC_ALWAYS:    jump = 1'b1;
      JC_MOD_SMALL: jump = (mod_q < W'(2));
      JC_BIT_CLR:   jump = !exp_q[0];
      JC_MORE:      jump = (cnt_q != CW'(W-1));
      JC_DECRYPT:   jump = (kind_q == REQ_DECRYPT);
      default:      jump = 1'b0;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q     <= W'(127);
      gen_q     <= W'(2);
      pub_q     <= W'(1);
      rkey_q    <= W'(1);
      skey_q    <= W'(1);
      busy_q    <= 1'b0;
      pc_q      <= PC_CHK;
      mul_run_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_MODULUS:      mod_q  <= cfg_data_i;
          REG_GENERATOR:    gen_q  <= cfg_data_i;
          REG_PUBLIC_KEY:   pub_q  <= cfg_data_i;
          REG_RECEIVER_KEY: rkey_q <= cfg_data_i;
          REG_SENDER_KEY:   skey_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        busy_q <= 1'b1;
        pc_q   <= PC_CHK;
      end
      if (mul_go) begin
        mul_run_q <= 1'b1;
      end else if (mul_run_q && mul_last) begin
        mul_run_q <= 1'b0;
      end
      if (step_done) begin
        pc_q <= jump ? word.target : pc_q + pc_t'(1);
      end
      // A new result takes the output register; otherwise a taken result empties it.
      if (step_done && (word.out != OUT_NONE)) begin
        m_valid_q <= 1'b1;
        busy_q    <= 1'b0;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      dat_q  <= s_axis_tdata[W-1:0];
    end
    if (mul_go) begin
      mr_q   <= '0;
      mx_q   <= x_val;
      ma_q   <= a_val;
      mcnt_q <= '0;
    end else if (mul_run_q) begin
      mr_q   <= red;
      mx_q   <= {mx_q[W-2:0], 1'b0};
      mcnt_q <= mcnt_q + CW'(1);
    end
    if (step_done) begin
      if (word.mul) begin
        unique case (word.dst)
          D_ACC:   acc_q <= red;
          D_SQ:    sq_q  <= red;
          default: ;
        endcase
      end
      if (word.acc_init) begin
        acc_q <= W'(1);
      end
      unique case (word.exp_ld)
        EXP_SENDER: begin
          exp_q <= skey_q;
          cnt_q <= '0;
        end
        EXP_DEC: begin
          exp_q <= exp_dec;
          cnt_q <= '0;
        end
        default: begin
          if (word.exp_shift) begin
            exp_q <= exp_q >> 1;
            cnt_q <= cnt_q + CW'(1);
          end
        end
      endcase
      if (word.eph_ld) begin
        eph_q <= acc_q;
      end
      unique case (word.out)
        OUT_MUL: begin
          out_res_q <= red;
          out_eph_q <= eph_q;
        end
        OUT_ZERO: begin
          out_res_q <= '0;
          out_eph_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({out_eph_q, out_res_q});

`ifndef SYNTHESIS
  a_mul_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_run_q |-> busy_q)
    else $error("multiplier running while the sequencer is idle");

  a_accept_starts_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && (pc_q == PC_CHK) && !mul_run_q)
    else $error("accepted transaction did not start the program at its first step");

  a_product_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_run_q && mul_last |-> (red < mod_q))
    else $error("modular product not reduced below the modulus");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PC_ZERO))
    else $error("step counter left the program");

  a_output_free_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_done && (word.out != OUT_NONE) |-> out_free)
    else $error("result written while the output register still holds one");
`endif

endmodule
